// File: rtl/skw_pkg.sv
// Shared types, constants and the exponential table function for the kernel weight unit.
package skw_pkg;

  localparam int WORD_W = 32;
  localparam int KIND_W = 3;
  localparam int FRAC_BITS = 16;
  localparam int EXP_DEPTH_DEFAULT = 256;

  // One quotient bit per divider stage.
  localparam int DIV_STAGES = WORD_W;
  localparam int EXP_LAT = 4;

  localparam logic [KIND_W-1:0] KIND_QUARTIC    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NORMAL     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNIFORM    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TRIANGULAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEGEXP     = 3'd4;

  localparam int R_SHIFT        = 30;
  localparam int R_SHIFT_NORMAL = 28;

  localparam logic [31:0] Q30_ONE         = 32'h4000_0000;
  localparam logic [30:0] K_THREE_OVER_PI = 31'd1025347913;
  localparam logic [30:0] K_INV_TWO_PI    = 31'd170891319;
  localparam logic [30:0] K_LOG2E         = 31'd1549082005;
  localparam logic [30:0] K_LN2           = 31'd744261118;
  localparam logic [31:0] SAT_MAX         = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [WORD_W-1:0] bandwidth;
    logic [WORD_W-1:0] dist_req;
    logic [WORD_W-1:0] weight_in;
  } skw_args_t;

  typedef struct packed {
    logic [WORD_W-1:0] weight_out;
    logic              bad_bandwidth;
  } skw_result_t;

  // Per-item control that rides along the whole pipeline.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              bad;
    logic              zero;
  } skw_ctl_t;

  typedef struct packed {
    skw_ctl_t    ctl;
    logic [31:0] d;
    logic [31:0] w;
  } skw_div1_side_t;

  typedef struct packed {
    skw_ctl_t    ctl;
    logic [31:0] t;
    logic [31:0] w;
    logic [30:0] q;
    logic [31:0] a;
    logic [31:0] tri_res;
  } skw_exp_side_t;

  typedef struct packed {
    skw_ctl_t    ctl;
    logic [31:0] direct;
    logic        sat;
  } skw_tail_t;

  // 2^-(k/depth) in Q30 from z = k*ln2/depth; evaluated only on constants.
  function automatic logic [30:0] exp_taylor(input logic [63:0] z);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'(Q30_ONE);
    pos  = 64'(Q30_ONE);
    neg  = 64'd0;
    for (int j = 1; j <= 12; j++) begin
      term = ((term * z) >> 30) / 64'(j);
      if (j[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? 31'(pos - neg) : 31'd0;
  endfunction

endpackage

// File: rtl/spatial_kernel_weight_unit.sv
// Top level of the kernel-density weight unit: input stage, datapath and result register.
// The unit takes one word on every clock in which start is high and busy is low; busy is
// high only in the cycle after reset. Each word's result appears on result with done high
// for exactly one cycle, a fixed 107 cycles after the word was taken, and must be captured
// then, since the receiver cannot stall the unit. The latency is set mostly by three
// 32-stage dividers (the distance ratio and the two divisions by the bandwidth) plus the
// four-stage exponential unit. kernel_kind is written through cfg_valid/cfg_ready and must
// only change while no word is in flight.
module spatial_kernel_weight_unit #(
  parameter int EXP_TABLE_DEPTH = skw_pkg::EXP_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  skw_pkg::skw_args_t         args,
  output logic                       done,
  output skw_pkg::skw_result_t       result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [skw_pkg::KIND_W-1:0] cfg_data
);
  import skw_pkg::*;

  localparam int PIPE_LAT = 1 + DIV_STAGES + 2 + EXP_LAT + 3 + 2 * DIV_STAGES + 1;

  logic [KIND_W-1:0] kernel_kind;
  logic              accept;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_kind <= KIND_QUARTIC;
    end else if (cfg_valid && cfg_ready) begin
      kernel_kind <= cfg_data;
    end
  end

  // Input stage.
  logic              s0_valid;
  skw_args_t         s0_args;
  logic [KIND_W-1:0] s0_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_args <= args;
    s0_kind <= kernel_kind;
  end

  skw_div1_side_t s0_side;
  logic [63:0]    r_dividend;

  always_comb begin
    s0_side.ctl.kind = s0_kind;
    s0_side.ctl.bad  = (s0_args.bandwidth == 32'd0);
    s0_side.ctl.zero = (s0_kind > KIND_NEGEXP) ||
                       ((s0_kind != KIND_NORMAL) && (s0_args.dist_req > s0_args.bandwidth));
    s0_side.d        = s0_args.dist_req;
    s0_side.w        = s0_args.weight_in;
    if (s0_kind == KIND_NORMAL) begin
      r_dividend = 64'(s0_args.dist_req) << R_SHIFT_NORMAL;
    end else begin
      r_dividend = 64'(s0_args.dist_req) << R_SHIFT;
    end
  end

  // Ratio d/t; the overflow flag marks a quotient of 2^32 or more (used by the normal kernel only).
  logic                       d1_valid;
  logic [31:0]                d1_quo;
  logic                       d1_ovf;
  logic [31:0]                d1_den;
  logic [$bits(skw_div1_side_t)-1:0] d1_side_raw;
  skw_div1_side_t             d1_side;

  skw_divider #(.SIDE_W($bits(skw_div1_side_t))) u_div_ratio (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s0_valid),
    .in_hi    (r_dividend[63:32]),
    .in_lo    (r_dividend[31:0]),
    .in_den   (s0_args.bandwidth),
    .in_side  (s0_side),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_ovf  (d1_ovf),
    .out_den  (d1_den),
    .out_side (d1_side_raw)
  );

  assign d1_side = d1_side_raw;

  // P1: square of the ratio (or the triangular product) and the scaled intensity.
  logic        p1_valid;
  skw_ctl_t    p1_ctl;
  logic [31:0] p1_t, p1_d, p1_w;
  logic [63:0] p1_m;
  logic [62:0] p1_aprod;
  logic        p1_big;

  logic        p1_tri;
  logic [31:0] op_a, op_b;
  logic [30:0] k_scale;

  always_comb begin
    p1_tri  = (d1_side.ctl.kind == KIND_TRIANGULAR);
    op_a    = p1_tri ? d1_side.w : d1_quo;
    op_b    = p1_tri ? 32'(Q30_ONE - d1_quo) : d1_quo;
    k_scale = (d1_side.ctl.kind == KIND_NORMAL) ? K_INV_TWO_PI : K_THREE_OVER_PI;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_ctl   <= d1_side.ctl;
    p1_t     <= d1_den;
    p1_d     <= d1_side.d;
    p1_w     <= d1_side.w;
    p1_m     <= 64'(op_a) * 64'(op_b);
    p1_aprod <= 63'(d1_side.w) * 63'(k_scale);
    p1_big   <= d1_ovf;
  end

  // P2: quartic base, exponent argument, triangular result.
  logic          p2_valid;
  logic [38:0]   p2_x;
  logic          p2_zero;
  skw_exp_side_t p2_side;

  logic [33:0]   d_times3;
  logic          nexp_zero;
  logic [38:0]   nexp_x;

  always_comb begin
    d_times3  = 34'(p1_d) + (34'(p1_d) << 1);
    nexp_zero = |(d_times3 >> (FRAC_BITS + 6));
    nexp_x    = 39'(d_times3) << (32 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_ctl.kind == KIND_NORMAL) begin
      p2_x    <= p1_m[63:25];
      p2_zero <= p1_big;
    end else begin
      p2_x    <= nexp_x;
      p2_zero <= nexp_zero;
    end
    p2_side.ctl     <= p1_ctl;
    p2_side.t       <= p1_t;
    p2_side.w       <= p1_w;
    p2_side.q       <= 31'(Q30_ONE) - p1_m[60:30];
    p2_side.a       <= p1_aprod[61:30];
    p2_side.tri_res <= p1_m[61:30];
  end

  logic                             e_valid;
  logic [30:0]                      e_val;
  logic [$bits(skw_exp_side_t)-1:0] e_side_raw;
  skw_exp_side_t                    e_side;

  skw_exp_unit #(
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
    .SIDE_W         ($bits(skw_exp_side_t))
  ) u_exp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p2_valid),
    .in_x     (p2_x),
    .in_zero  (p2_zero),
    .in_side  (p2_side),
    .out_valid(e_valid),
    .out_e    (e_val),
    .out_side (e_side_raw)
  );

  assign e_side = e_side_raw;

  // P3: the shape factor in Q30.
  logic        p3_valid;
  skw_ctl_t    p3_ctl;
  logic [31:0] p3_t, p3_w, p3_a, p3_tri;
  logic [30:0] p3_sel;
  logic [61:0] q_sq;

  assign q_sq = 62'(e_side.q) * 62'(e_side.q);

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    p3_ctl <= e_side.ctl;
    p3_t   <= e_side.t;
    p3_w   <= e_side.w;
    p3_a   <= e_side.a;
    p3_tri <= e_side.tri_res;
    p3_sel <= (e_side.ctl.kind == KIND_QUARTIC) ? q_sq[60:30] : e_val;
  end

  // P4: scale by the intensity term.
  logic        p4_valid;
  skw_ctl_t    p4_ctl;
  logic [31:0] p4_t, p4_w, p4_tri;
  logic [62:0] p4_bprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    p4_ctl   <= p3_ctl;
    p4_t     <= p3_t;
    p4_w     <= p3_w;
    p4_tri   <= p3_tri;
    p4_bprod <= 63'((p3_ctl.kind == KIND_NEGEXP) ? p3_w : p3_a) * 63'(p3_sel);
  end

  // P5: kernels that need no division by t^2 take their result here.
  logic        p5_valid;
  logic [31:0] p5_t;
  logic [31:0] p5_b;
  skw_tail_t   p5_tail;
  logic [31:0] p5_direct;

  always_comb begin
    case (p4_ctl.kind)
      KIND_UNIFORM:    p5_direct = p4_w;
      KIND_TRIANGULAR: p5_direct = p4_tri;
      default:         p5_direct = p4_bprod[61:30];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid <= 1'b0;
    end else begin
      p5_valid <= p4_valid;
    end
  end

  always_ff @(posedge clk) begin
    p5_t           <= p4_t;
    p5_b           <= p4_bprod[61:30];
    p5_tail.ctl    <= p4_ctl;
    p5_tail.direct <= p5_direct;
    p5_tail.sat    <= 1'b0;
  end

  logic [63:0] b_dividend;
  assign b_dividend = 64'(p5_b) << FRAC_BITS;

  logic                         d2_valid;
  logic [31:0]                  d2_quo;
  logic                         d2_ovf;
  logic [31:0]                  d2_den;
  logic [$bits(skw_tail_t)-1:0] d2_side_raw;
  skw_tail_t                    d2_side;
  skw_tail_t                    d3_in_side;

  skw_divider #(.SIDE_W($bits(skw_tail_t))) u_div_first (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p5_valid),
    .in_hi    (b_dividend[63:32]),
    .in_lo    (b_dividend[31:0]),
    .in_den   (p5_t),
    .in_side  (p5_tail),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_ovf  (d2_ovf),
    .out_den  (d2_den),
    .out_side (d2_side_raw)
  );

  assign d2_side = d2_side_raw;

  logic [63:0] c_dividend;

  always_comb begin
    c_dividend     = 64'(d2_quo) << FRAC_BITS;
    d3_in_side     = d2_side;
    d3_in_side.sat = d2_side.sat | d2_ovf;
  end

  logic                         d3_valid;
  logic [31:0]                  d3_quo;
  logic                         d3_ovf;
  logic [$bits(skw_tail_t)-1:0] d3_side_raw;
  skw_tail_t                    d3_side;

  skw_divider #(.SIDE_W($bits(skw_tail_t))) u_div_second (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d2_valid),
    .in_hi    (c_dividend[63:32]),
    .in_lo    (c_dividend[31:0]),
    .in_den   (d2_den),
    .in_side  (d3_in_side),
    .out_valid(d3_valid),
    .out_quo  (d3_quo),
    .out_ovf  (d3_ovf),
    .out_den  (),
    .out_side (d3_side_raw)
  );

  assign d3_side = d3_side_raw;

  // Result register.
  logic [31:0] weight_next;

  always_comb begin
    if (d3_side.ctl.bad || d3_side.ctl.zero) begin
      weight_next = 32'd0;
    end else begin
      case (d3_side.ctl.kind) inside
        KIND_UNIFORM, KIND_TRIANGULAR, KIND_NEGEXP: weight_next = d3_side.direct;
        default: weight_next = (d3_side.sat || d3_ovf) ? SAT_MAX : d3_quo;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.weight_out    <= weight_next;
    result.bad_bandwidth <= d3_side.ctl.bad;
  end

`ifndef SYNTHESIS
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LAT))
    else $error("done without a word taken at the pipeline latency");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.bad_bandwidth) |-> (result.weight_out == 32'd0))
    else $error("bad bandwidth with nonzero weight");

  a_bad_source: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.bad_bandwidth == ($past(args.bandwidth, PIPE_LAT) == 32'd0)))
    else $error("bad_bandwidth does not match the bandwidth taken");
`endif

endmodule

// File: rtl/skw_divider.sv
// Pipelined restoring divider: a 64-bit dividend by a 32-bit divisor, one quotient bit a stage.
module skw_divider #(
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [skw_pkg::WORD_W-1:0] in_hi,
  input  logic [skw_pkg::WORD_W-1:0] in_lo,
  input  logic [skw_pkg::WORD_W-1:0] in_den,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [skw_pkg::WORD_W-1:0] out_quo,
  output logic                     out_ovf,
  output logic [skw_pkg::WORD_W-1:0] out_den,
  output logic [SIDE_W-1:0]        out_side
);
  import skw_pkg::*;

  localparam int N = DIV_STAGES;

  logic [N-1:0]        vld;
  logic [WORD_W-1:0]   rem     [N];
  logic [WORD_W-1:0]   lo      [N];
  logic [WORD_W-1:0]   den     [N];
  logic [WORD_W-1:0]   quo     [N];
  logic [N-1:0]        ovf;
  logic [SIDE_W-1:0]   side    [N];

  logic [WORD_W-1:0]   rem_next [N];
  logic [WORD_W-1:0]   quo_next [N];

  always_comb begin
    logic [WORD_W:0]   tmp;
    logic              ge;
    logic [WORD_W-1:0] r_in;
    logic [WORD_W-1:0] l_in;
    logic [WORD_W-1:0] d_in;
    logic [WORD_W-1:0] q_in;
    for (int g = 0; g < N; g++) begin
      if (g == 0) begin
        r_in = in_hi;
        l_in = in_lo;
        d_in = in_den;
        q_in = '0;
      end else begin
        r_in = rem[g-1];
        l_in = lo[g-1];
        d_in = den[g-1];
        q_in = quo[g-1];
      end
      tmp = {r_in, l_in[WORD_W-1]};
      ge  = (tmp >= {1'b0, d_in});
      rem_next[g] = ge ? WORD_W'(tmp - {1'b0, d_in}) : tmp[WORD_W-1:0];
      quo_next[g] = {q_in[WORD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= rem_next[0];
    quo[0]  <= quo_next[0];
    lo[0]   <= in_lo << 1;
    den[0]  <= in_den;
    ovf[0]  <= (in_hi >= in_den);
    side[0] <= in_side;
    for (int g = 1; g < N; g++) begin
      rem[g]  <= rem_next[g];
      quo[g]  <= quo_next[g];
      lo[g]   <= lo[g-1] << 1;
      den[g]  <= den[g-1];
      ovf[g]  <= ovf[g-1];
      side[g] <= side[g-1];
    end
  end

  assign out_valid = vld[N-1];
  assign out_quo   = quo[N-1];
  assign out_ovf   = ovf[N-1];
  assign out_den   = den[N-1];
  assign out_side  = side[N-1];

endmodule

// File: rtl/skw_exp_unit.sv
// Pipelined exp(-x) for x in Q32: base-2 range reduction, table lookup and a right shift.
module skw_exp_unit #(
  parameter int EXP_TABLE_DEPTH = skw_pkg::EXP_DEPTH_DEFAULT,
  parameter int SIDE_W          = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [38:0]       in_x,
  input  logic              in_zero,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [30:0]       out_e,
  output logic [SIDE_W-1:0] out_side
);
  import skw_pkg::*;

  localparam int IW = $clog2(EXP_TABLE_DEPTH);

  logic [30:0] rom [EXP_TABLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] Z = (64'(k) * 64'(K_LN2)) / 64'(EXP_TABLE_DEPTH);
    assign rom[k] = exp_taylor(Z);
  end

  logic              s1_valid, s2_valid, s3_valid;
  logic [62:0]       s1_prod;
  logic              s1_zero, s2_zero, s3_zero;
  logic [SIDE_W-1:0] s1_side, s2_side, s3_side;
  logic [IW-1:0]     s2_idx;
  logic [4:0]        s2_n, s3_n;
  logic [30:0]       s3_rom;

  logic [38:0]       y;
  logic [63:0]       idx_prod;

  assign y        = s1_prod[62:24];
  assign idx_prod = 64'(y[31:0]) * 64'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    // x at or above 64 underflows to zero.
    s1_prod <= 63'(in_x[37:6]) * 63'(K_LOG2E);
    s1_zero <= in_zero | in_x[38];
    s1_side <= in_side;

    s2_idx  <= idx_prod[32 +: IW];
    s2_n    <= y[36:32];
    s2_zero <= s1_zero | (y[38:32] >= 7'd31);
    s2_side <= s1_side;

    s3_rom  <= rom[s2_idx];
    s3_n    <= s2_n;
    s3_zero <= s2_zero;
    s3_side <= s2_side;

    out_e    <= s3_zero ? 31'd0 : (s3_rom >> s3_n);
    out_side <= s3_side;
  end

endmodule
